// ----- design/becp_pkg.sv -----
// ============================================================================
// becp_pkg
// Shared types and constants for the binomial European call pricer.
// ============================================================================
package becp_pkg;

   // Default tree depth
   localparam int MAX_LEVELS_DEF = 64;

   // Field widths
   localparam int PRICE_W    = 32;
   localparam int PROB_W     = 25;
   localparam int LEVEL_W    = 7;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Fixed-point constants
   localparam logic [PROB_W-1:0] ONE_Q24   = 25'h100_0000;
   localparam logic [23:0]       HALF_Q24  = 24'h80_0000;
   localparam logic [29:0]       HALF_Q30  = 30'h2000_0000;

   // Register reset values
   localparam logic [PRICE_W-1:0] SPOT_RST   = 32'd6553600;
   localparam logic [PRICE_W-1:0] UP_RST     = 32'd1073741824;
   localparam logic [PRICE_W-1:0] RATIO_RST  = 32'd1073741824;
   localparam logic [PROB_W-1:0]  PROB_RST   = 25'd8388608;
   localparam logic [PROB_W-1:0]  DISC_RST   = 25'd16777216;
   localparam logic [LEVEL_W-1:0] LEVELS_RST = 7'd60;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      CSR_SPOT   = 3'd0,
      CSR_UP     = 3'd1,
      CSR_RATIO  = 3'd2,
      CSR_PROB   = 3'd3,
      CSR_DISC   = 3'd4,
      CSR_LEVELS = 3'd5
   } csr_idx_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_LEAF,
      ST_FOLD,
      ST_FINISH
   } state_type;

   // Node read issued to the fold pipeline
   typedef struct packed {
      logic valid;
      logic first;   // first read of a level, no node produced
   } fold_ctl_type;

   // Fold pipeline status back to the sequencer
   typedef struct packed {
      logic hazard;  // read address has a write still in flight
      logic busy;    // any stage occupied
   } fold_sts_type;

endpackage

// ----- design/becp_fold.sv -----
// ============================================================================
// becp_fold
// Three-stage backward-induction datapath: one parent node per read after the first of a level.
// ============================================================================
module becp_fold
   import becp_pkg::*;
#(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF,
   localparam int ADDR_W = $clog2(MAX_LEVELS)
)
(
   input  logic                clock,
   input  logic                reset,
   input  fold_ctl_type        issue,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic [PRICE_W-1:0]  rd_data,
   input  logic [PROB_W-1:0]   prob,
   input  logic [PROB_W-1:0]   disc,
   output fold_sts_type        sts,
   output logic                wr_valid,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [PRICE_W-1:0]  wr_data
);

   // Stage 1: read data arrives, p*(upper-lower)
   logic                s1_valid_ff, s1_first_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [PRICE_W-1:0]  prev_ff;
   logic [ADDR_W-1:0]   s1_waddr;
   logic signed [32:0]  diff;
   logic signed [58:0]  prod;
   logic                s1_produce;

   // Stage 2: add lower*2^24 and round
   logic                s2_valid_ff;
   logic [ADDR_W-1:0]   s2_addr_ff;
   logic [PRICE_W-1:0]  s2_lower_ff;
   logic signed [58:0]  s2_prod_ff;
   logic signed [59:0]  mix_sum;

   // Stage 3: discount and write back
   logic                s3_valid_ff;
   logic [ADDR_W-1:0]   s3_addr_ff;
   logic [PRICE_W-1:0]  s3_m_ff;
   logic [56:0]         disc_sum;

   assign s1_waddr   = s1_addr_ff - ADDR_W'(1);
   assign s1_produce = s1_valid_ff & ~s1_first_ff;
   assign diff       = $signed({1'b0, prev_ff}) - $signed({1'b0, rd_data});
   assign prod       = $signed({1'b0, prob}) * diff;

   assign mix_sum = $signed({4'b0000, s2_lower_ff, 24'h00_0000})
                  + $signed({s2_prod_ff[58], s2_prod_ff})
                  + $signed({36'd0, HALF_Q24});

   assign disc_sum = 57'(s3_m_ff) * 57'(disc) + 57'(HALF_Q24);

   // Control of the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue.valid;
         s2_valid_ff <= s1_produce;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_first_ff <= issue.first;
      s1_addr_ff  <= rd_addr;
      if (s1_valid_ff) begin
         prev_ff <= rd_data;
      end
      s2_addr_ff  <= s1_waddr;
      s2_lower_ff <= rd_data;
      s2_prod_ff  <= prod;
      s3_addr_ff  <= s2_addr_ff;
      s3_m_ff     <= mix_sum[55:24];
   end

   // A read must not overtake a pending write to the same node
   assign sts.hazard = (s1_produce && s1_waddr == rd_addr)
                    || (s2_valid_ff && s2_addr_ff == rd_addr)
                    || (s3_valid_ff && s3_addr_ff == rd_addr);
   assign sts.busy   = s1_valid_ff | s2_valid_ff | s3_valid_ff;

   assign wr_valid = s3_valid_ff;
   assign wr_addr  = s3_addr_ff;
   assign wr_data  = disc_sum[55:24];

endmodule

// ----- design/binomial_european_call_pricer_core.sv -----
// ============================================================================
// binomial_european_call_pricer_core
// European call on a recombining binomial tree, folded in a node memory.
// ============================================================================
//
//  Channel  Dir  Handshake            Payload
//  req      in   req_tvalid/tready    tdata[31:0] strike
//  rsp      out  rsp_tvalid/tready    tdata[31:0] option_value, tuser[0] saturated
//  csr      in   APB, pready tied 1   spot, up, ratio, prob, disc, levels
//
//  A request runs the up chain, the leaf fill and the level-by-level fold, plus
//  hazard stalls on the two shortest levels.
//  The single read port of the node memory sets this: one node read a cycle, outside hazard stalls.
//  Reset is synchronous; there is no memory clearing pass.
//  A new request is taken as soon as the previous result sits in the output
//  register; a stalled output only holds the block in its final state.
//
module binomial_european_call_pricer_core
   import becp_pkg::*;
#(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [31:0] strike
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [31:0] option_value
   output logic [0:0]             rsp_tuser,   // [0] saturated
   // configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int ADDR_W = $clog2(MAX_LEVELS);
   localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
   localparam int CMP_W  = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;

   // Configuration registers
   logic [PRICE_W-1:0] spot_ff, up_ff, ratio_ff;
   logic [PROB_W-1:0]  prob_ff, disc_ff;
   logic [LEVEL_W-1:0] levels_ff;
   logic               csr_write;
   csr_idx_type        csr_idx;

   // Sequencer state
   state_type          state_ff, state_in;
   logic [LVL_W-1:0]   idx_ff, idx_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [LVL_W-1:0]   n_ff, n_in;
   logic [PRICE_W-1:0] leaf_ff, leaf_in;
   logic [PRICE_W-1:0] strike_ff, strike_in;
   logic               sat_ff, sat_in;
   logic [PRICE_W-1:0] result_ff;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // Node memory
   logic [PRICE_W-1:0] node_values_ff [MAX_LEVELS];
   logic [PRICE_W-1:0] rd_data_ff;
   logic               rd_en;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [PRICE_W-1:0] mem_wdata;
   logic               leaf_we;

   // Datapath helpers
   logic [CMP_W-1:0]   lc_ext;
   logic [LVL_W-1:0]   n_eff;
   logic [PROB_W-1:0]  prob_eff, disc_eff;
   logic [PRICE_W-1:0] factor;
   logic [63:0]        mul_sum;
   logic [PRICE_W-1:0] mul_res;
   logic               mul_ovf;
   logic [PRICE_W-1:0] payoff;

   // Fold pipeline
   fold_ctl_type       fold_issue;
   fold_sts_type       fold_sts;
   logic               fold_wr_valid;
   logic [ADDR_W-1:0]  fold_wr_addr;
   logic [PRICE_W-1:0] fold_wr_data;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         spot_ff   <= SPOT_RST;
         up_ff     <= UP_RST;
         ratio_ff  <= RATIO_RST;
         prob_ff   <= PROB_RST;
         disc_ff   <= DISC_RST;
         levels_ff <= LEVELS_RST;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_SPOT:   spot_ff   <= csr_pwdata[PRICE_W-1:0];
            CSR_UP:     up_ff     <= csr_pwdata[PRICE_W-1:0];
            CSR_RATIO:  ratio_ff  <= csr_pwdata[PRICE_W-1:0];
            CSR_PROB:   prob_ff   <= csr_pwdata[PROB_W-1:0];
            CSR_DISC:   disc_ff   <= csr_pwdata[PROB_W-1:0];
            CSR_LEVELS: levels_ff <= csr_pwdata[LEVEL_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SPOT:   csr_prdata = CSR_DATA_W'(spot_ff);
         CSR_UP:     csr_prdata = CSR_DATA_W'(up_ff);
         CSR_RATIO:  csr_prdata = CSR_DATA_W'(ratio_ff);
         CSR_PROB:   csr_prdata = CSR_DATA_W'(prob_ff);
         CSR_DISC:   csr_prdata = CSR_DATA_W'(disc_ff);
         CSR_LEVELS: csr_prdata = CSR_DATA_W'(levels_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Clamped operands
   // ---------------------------------------------------------------------
   assign lc_ext = CMP_W'(levels_ff);

   always_comb begin
      priority if (lc_ext == '0) begin
         n_eff = LVL_W'(1);
      end else if (lc_ext > CMP_W'(MAX_LEVELS)) begin
         n_eff = LVL_W'(MAX_LEVELS);
      end else begin
         n_eff = LVL_W'(lc_ext);
      end
   end

   assign prob_eff = (prob_ff > ONE_Q24) ? ONE_Q24 : prob_ff;
   assign disc_eff = (disc_ff > ONE_Q24) ? ONE_Q24 : disc_ff;

   // ---------------------------------------------------------------------
   // Leaf price multiplier, Q2.30 factor, round and clip
   // ---------------------------------------------------------------------
   assign factor  = (state_ff == ST_UP) ? up_ff : ratio_ff;
   assign mul_sum = 64'(leaf_ff) * 64'(factor) + 64'(HALF_Q30);
   assign mul_ovf = |mul_sum[63:62];
   assign mul_res = mul_ovf ? {PRICE_W{1'b1}} : mul_sum[61:30];
   assign payoff  = (leaf_ff > strike_ff) ? (leaf_ff - strike_ff) : '0;

   // ---------------------------------------------------------------------
   // Sequencer: up chain, leaf fill, level-by-level fold, result
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      level_in     = level_ff;
      n_in         = n_ff;
      leaf_in      = leaf_ff;
      strike_in    = strike_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      leaf_we      = 1'b0;
      rd_en        = 1'b0;
      fold_issue   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               strike_in = req_tdata;
               n_in      = n_eff;
               leaf_in   = spot_ff;
               sat_in    = 1'b0;
               idx_in    = n_eff - LVL_W'(1);
               state_in  = ST_UP;
            end
         end
         ST_UP: begin
            if (idx_ff == '0) begin
               state_in = ST_LEAF;
            end else begin
               leaf_in = mul_res;
               sat_in  = sat_ff | mul_ovf;
               idx_in  = idx_ff - LVL_W'(1);
            end
         end
         ST_LEAF: begin
            leaf_we = 1'b1;
            if (idx_ff == n_ff - LVL_W'(1)) begin
               level_in = n_ff - LVL_W'(1);
               idx_in   = '0;
               state_in = (n_ff == LVL_W'(1)) ? ST_FINISH : ST_FOLD;
            end else begin
               leaf_in = mul_res;
               sat_in  = sat_ff | mul_ovf;
               idx_in  = idx_ff + LVL_W'(1);
            end
         end
         ST_FOLD: begin
            // level_ff parents need level_ff+1 child reads
            if (!fold_sts.hazard) begin
               rd_en            = 1'b1;
               fold_issue.valid = 1'b1;
               fold_issue.first = (idx_ff == '0);
               if (idx_ff == level_ff) begin
                  idx_in = '0;
                  if (level_ff == LVL_W'(1)) begin
                     state_in = ST_FINISH;
                  end else begin
                     level_in = level_ff - LVL_W'(1);
                  end
               end else begin
                  idx_in = idx_ff + LVL_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!fold_sts.busy && (!rsp_valid_ff || rsp_tready)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         level_ff     <= '0;
         n_ff         <= '0;
         leaf_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         level_ff     <= level_in;
         n_ff         <= n_in;
         leaf_ff      <= leaf_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      strike_ff   <= strike_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
      // root value is the last word written to node 0
      if (mem_we && mem_waddr == '0) begin
         result_ff <= mem_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // Node memory: one write port, one registered read port
   // ---------------------------------------------------------------------
   assign mem_we    = leaf_we | fold_wr_valid;
   assign mem_waddr = leaf_we ? idx_ff[ADDR_W-1:0] : fold_wr_addr;
   assign mem_wdata = leaf_we ? payoff : fold_wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_values_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= node_values_ff[idx_ff[ADDR_W-1:0]];
      end
   end

   // ---------------------------------------------------------------------
   // Fold datapath
   // ---------------------------------------------------------------------
   becp_fold #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_fold (
      .clock    (clock),
      .reset    (reset),
      .issue    (fold_issue),
      .rd_addr  (idx_ff[ADDR_W-1:0]),
      .rd_data  (rd_data_ff),
      .prob     (prob_eff),
      .disc     (disc_eff),
      .sts      (fold_sts),
      .wr_valid (fold_wr_valid),
      .wr_addr  (fold_wr_addr),
      .wr_data  (fold_wr_data)
   );

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// ----- design/becp_checker.sv -----
// ============================================================================
// becp_checker
// Port-level checks for the binomial call pricer, bound to the top level.
// ============================================================================
module becp_checker
   import becp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [31:0]            req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [31:0]            rsp_tdata,
   input logic [0:0]             rsp_tuser,
   input logic                   csr_psel,
   input logic                   csr_penable,
   input logic                   csr_pwrite,
   input logic [CSR_ADDR_W-1:0]  csr_paddr,
   input logic [CSR_DATA_W-1:0]  csr_pwdata,
   input logic [CSR_DATA_W-1:0]  csr_prdata,
   input logic                   csr_pready
);

   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // One request in work at a time: busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a tree was in work");

   // A result appears only as the block returns to idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready && !$past(req_tready))
      else $error("response not aligned with end of work");

   // No response can come out of an idle block without a request
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tready && !req_tvalid |=> !rsp_tvalid)
      else $error("response without a request");

endmodule

bind binomial_european_call_pricer_core becp_checker u_becp_checker (.*);

// ----- tb/call_price_checker.sv -----
// ============================================================================
// call_price_checker
// Watches the strike, result and register channels of the call pricer,
// prices every accepted strike on its own copy of the tree settings and
// compares each returned call value and saturation flag in order, and checks register read data.
// ============================================================================
module call_price_checker
   import becp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] strike
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [31:0]           rsp_tdata,   // [31:0] option_value
   input  logic [0:0]            rsp_tuser,   // [0] saturated
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    pending,
   output int                    results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TREE_DEPTH = MAX_LEVELS_DEF;
   localparam logic [CSR_ADDR_W-1:0] REG_SPAN = 5'd24;

   typedef struct packed {
      logic [31:0] option_value;
      logic        saturated;
   } call_result_type;

   // shadow copy of the tree settings
   logic [31:0]        cfg_spot;
   logic [31:0]        cfg_up;
   logic [31:0]        cfg_ratio;
   logic [PROB_W-1:0]  cfg_prob;
   logic [PROB_W-1:0]  cfg_disc;
   logic [LEVEL_W-1:0] cfg_levels;

   call_result_type expected_prices[$];
   call_result_type want;
   int              errs = 0;
   int              results = 0;

   initial begin
      failures = 0;
      pending = 0;
      results_seen = 0;
   end

   // x * f in Q2.30, round half up; bit 32 flags a clipped product
   function automatic logic [32:0] scale_q30(input logic [31:0] x, input logic [31:0] f);
      logic [63:0] prod;
      prod = (64'(x) * 64'(f) + 64'(HALF_Q30)) >> 30;
      if (prod > 64'hFFFF_FFFF) return {1'b1, 32'hFFFF_FFFF};
      return {1'b0, prod[31:0]};
   endfunction

   // root value of the call tree for one strike
   function automatic call_result_type price_call(input logic [31:0] strike);
      logic [31:0]     node [TREE_DEPTH];
      logic [31:0]     price;
      logic [32:0]     scaled;
      logic [63:0]     pw, qw, dw, mid, val;
      int unsigned     n, lvl, k;
      logic            clip;
      call_result_type res;
      pw = (cfg_prob > ONE_Q24) ? 64'(ONE_Q24) : 64'(cfg_prob);
      qw = 64'(ONE_Q24) - pw;
      dw = (cfg_disc > ONE_Q24) ? 64'(ONE_Q24) : 64'(cfg_disc);
      if (cfg_levels == 0) n = 1;
      else if (cfg_levels > TREE_DEPTH) n = TREE_DEPTH;
      else n = cfg_levels;
      clip = 1'b0;
      // climb to the top leaf
      price = cfg_spot;
      for (lvl = 1; lvl < n; lvl++) begin
         scaled = scale_q30(price, cfg_up);
         clip |= scaled[32];
         price = scaled[31:0];
      end
      // leaf payoffs, stepping down by the ratio
      for (k = 0; k < n; k++) begin
         node[k] = (price > strike) ? price - strike : 32'd0;
         if (k + 1 < n) begin
            scaled = scale_q30(price, cfg_ratio);
            clip |= scaled[32];
            price = scaled[31:0];
         end
      end
      // backward induction
      for (lvl = n - 1; lvl > 0; lvl--) begin
         for (k = 0; k < lvl; k++) begin
            mid = (pw * node[k] + qw * node[k+1] + 64'(HALF_Q24)) >> 24;
            val = (mid * dw + 64'(HALF_Q24)) >> 24;
            node[k] = (val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : val[31:0];
         end
      end
      res.option_value = node[0];
      res.saturated = clip;
      return res;
   endfunction

   function automatic logic [31:0] reg_value(input csr_idx_type idx);
      case (idx)
         CSR_SPOT:   return cfg_spot;
         CSR_UP:     return cfg_up;
         CSR_RATIO:  return cfg_ratio;
         CSR_PROB:   return 32'(cfg_prob);
         CSR_DISC:   return 32'(cfg_disc);
         CSR_LEVELS: return 32'(cfg_levels);
         default:    return 32'd0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_spot   = SPOT_RST;
         cfg_up     = UP_RST;
         cfg_ratio  = RATIO_RST;
         cfg_prob   = PROB_RST;
         cfg_disc   = DISC_RST;
         cfg_levels = LEVELS_RST;
         expected_prices.delete();
      end else begin
         // register writes and reads
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_idx_type'(csr_paddr[4:2]))
                  CSR_SPOT:   cfg_spot   = csr_pwdata;
                  CSR_UP:     cfg_up     = csr_pwdata;
                  CSR_RATIO:  cfg_ratio  = csr_pwdata;
                  CSR_PROB:   cfg_prob   = csr_pwdata[PROB_W-1:0];
                  CSR_DISC:   cfg_disc   = csr_pwdata[PROB_W-1:0];
                  CSR_LEVELS: cfg_levels = csr_pwdata[LEVEL_W-1:0];
                  default: ;
               endcase
            end else if (csr_paddr < REG_SPAN && csr_paddr[1:0] == 2'b00) begin
               if (csr_prdata !== reg_value(csr_idx_type'(csr_paddr[4:2]))) begin
                  $error("prdata mismatch at 0x%0h: expected 0x%0h, actual 0x%0h", csr_paddr,
                         reg_value(csr_idx_type'(csr_paddr[4:2])), csr_prdata);
                  errs++;
               end
            end
         end
         // strike request accepted
         if (req_tvalid && req_tready)
            expected_prices.insert(expected_prices.size(), price_call(req_tdata));
         // result accepted
         if (rsp_tvalid && rsp_tready) begin
            results++;
            if (expected_prices.size() == 0) begin
               $error("unexpected result: option_value 0x%0h saturated %0d", rsp_tdata,
                      rsp_tuser[0]);
               errs++;
            end else begin
               want = expected_prices.pop_front();
               if (rsp_tdata !== want.option_value) begin
                  $error("option_value mismatch: expected 0x%0h, actual 0x%0h",
                         want.option_value, rsp_tdata);
                  errs++;
               end
               if (rsp_tuser[0] !== want.saturated) begin
                  $error("saturated mismatch: expected %0d, actual %0d",
                         want.saturated, rsp_tuser[0]);
                  errs++;
               end
            end
         end
      end
      failures <= errs;
      pending <= expected_prices.size();
      results_seen <= results;
   end

endmodule

// ----- tb/binomial_european_call_pricer_core_test.sv -----
// ============================================================================
// binomial_european_call_pricer_core_test
// Drives strikes and tree settings into the call pricer with random idling
// and a long output stall; a checker beside the block predicts and compares.
// ============================================================================
module binomial_european_call_pricer_core_test;
   import becp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLDOFF_CYCLES = 2500;
   localparam int HOLDOFF_AT = 100;
   localparam int IDLE_PCT = 34;
   localparam int RANDOM_PHASES = 10;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE_LO = 5'd24;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE_HI = 5'd28;
   localparam logic [31:0] UNITY_Q30 = 32'h4000_0000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;   // [31:0] strike
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // [31:0] option_value
   logic [0:0]            rsp_tuser;        // [0] saturated
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures, pending, results_seen;
   int sent = 0;
   int settings_applied = 0;
   int cycles = 0;
   bit quiet = 1'b0;

   always #6 clock = ~clock;

   binomial_european_call_pricer_core dut (.*);

   call_price_checker u_price_checker (.*);

   // byte address of a register
   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input csr_idx_type idx);
      return {idx, 2'b00};
   endfunction

   // one APB transfer; psel stays up for a back-to-back transfer
   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic read_back();
      for (int i = 0; i <= int'(CSR_LEVELS); i++)
         csr_access(1'b0, reg_addr(csr_idx_type'(i)), '0);
      csr_release();
   endtask

   task automatic set_tree(input logic [31:0] spot, input logic [31:0] up,
                           input logic [31:0] ratio, input logic [24:0] prob,
                           input logic [24:0] disc, input logic [6:0] levels);
      csr_access(1'b1, reg_addr(CSR_SPOT), spot);
      csr_access(1'b1, reg_addr(CSR_UP), up);
      csr_access(1'b1, reg_addr(CSR_RATIO), ratio);
      csr_access(1'b1, reg_addr(CSR_PROB), 32'(prob));
      csr_access(1'b1, reg_addr(CSR_DISC), 32'(disc));
      csr_access(1'b1, reg_addr(CSR_LEVELS), 32'(levels));
      read_back();
      settings_applied++;
   endtask

   // offer one strike, with a random gap in front of it
   task automatic send_strike(input logic [31:0] strike);
      int gap;
      gap = (!quiet && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= strike;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sent++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // result side backpressure, with one long hold-off
   initial begin
      int  hold_left;
      bit  held;
      logic next_ready;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= HOLDOFF_AT) begin
            held = 1'b1;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (quiet) begin
            next_ready = 1'b1;
         end else begin
            next_ready = ($urandom_range(99) >= IDLE_PCT);
         end
         @(posedge clock);
         rsp_tready <= next_ready;
      end
   end

   // run limit
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int          phase, k, n_items;
      logic [31:0] spot_v, up_v, ratio_v, strike_v, off;
      logic [24:0] prob_v, disc_v;
      logic [6:0]  lvl_v;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back();

      // reset settings: flat tree, 60 levels
      send_strike(32'd0);
      send_strike(32'd6553600);
      send_strike(32'd6553599);
      send_strike(32'hFFFF_FFFF);
      settle();

      // level count zero acts as a single level, top spot price
      set_tree(32'hFFFF_FFFF, UNITY_Q30, UNITY_Q30, PROB_RST, DISC_RST, 7'd0);
      send_strike(32'd0);
      send_strike(32'hFFFF_FFFF);
      send_strike(32'd1);
      settle();

      // single level: payoff right at the spot price
      set_tree(32'h0012_3456, UNITY_Q30, UNITY_Q30, PROB_RST, DISC_RST, 7'd1);
      send_strike(32'h0012_3455);
      send_strike(32'h0012_3456);
      send_strike(32'h0012_3457);
      settle();

      // level count above the maximum, probability and discount above one,
      // up factor large enough to clip
      set_tree(32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 25'h1FF_FFFF, 25'h1FF_FFFF, 7'd127);
      send_strike(32'd0);
      send_strike(32'h7FFF_FFFF);
      settle();

      // full depth with zero probability and zero discount
      set_tree(32'd6553600, 32'h4147_AE14, 32'h3EB8_51EC, 25'd0, 25'd0, 7'd64);
      send_strike(32'd0);
      settle();

      // two levels, everything at its top value; spare addresses ignored
      set_tree(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ONE_Q24, ONE_Q24, 7'd2);
      csr_access(1'b1, ADDR_SPARE_LO, $urandom);
      csr_access(1'b1, ADDR_SPARE_HI, $urandom);
      read_back();
      send_strike(32'd0);
      send_strike(32'hFFFF_FFFF);
      settle();

      // random settings and strikes
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         quiet = (phase == 3);
         case ($urandom_range(3))
            0:       spot_v = $urandom;
            default: spot_v = $urandom_range(32'h0001_0000, 32'h00C8_0000);
         endcase
         up_v = ($urandom_range(4) == 0) ? $urandom : UNITY_Q30 + $urandom_range(0, 1 << 26);
         ratio_v = ($urandom_range(4) == 0) ? $urandom
                                            : UNITY_Q30 - $urandom_range(0, 1 << 27);
         prob_v = ($urandom_range(4) == 0) ? 25'($urandom) : 25'($urandom_range(0, ONE_Q24));
         disc_v = ($urandom_range(4) == 0) ? 25'($urandom)
                                           : 25'(ONE_Q24 - $urandom_range(0, 1 << 20));
         if (phase == 6) begin
            lvl_v = ($urandom_range(3) == 0) ? 7'($urandom_range(65, 127))
                                             : 7'($urandom_range(48, 64));
            n_items = 4;
         end else begin
            lvl_v = ($urandom_range(7) == 0) ? 7'($urandom_range(0, 20))
                                             : 7'($urandom_range(1, 12));
            n_items = 27;
         end
         set_tree(spot_v, up_v, ratio_v, prob_v, disc_v, lvl_v);
         for (k = 0; k < n_items; k++) begin
            off = $urandom_range(0, 32'h00FF_FFFF);
            case ($urandom_range(3))
               0:       strike_v = $urandom;
               1:       strike_v = (spot_v > off) ? spot_v - off : 32'd0;
               2:       strike_v = (spot_v > 32'hFFFF_FFFF - off) ? 32'hFFFF_FFFF
                                                                   : spot_v + off;
               default: strike_v = $urandom_range(0, 32'h00FF_FFFF);
            endcase
            send_strike(strike_v);
         end
         settle();
      end
      quiet = 1'b0;

      repeat (100) @(posedge clock);
      $display("Summary: %0d strikes sent, %0d results checked, %0d tree settings applied",
               sent, results_seen, settings_applied);
      $display("Covered single to full depth, clamped settings, clipping and a long stall");
      if (failures == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
